// ===== rtl/mhs_pkg.sv =====
`timescale 1ns / 1ps
package mhs_pkg;

  localparam int NUM_HASHES = 1024;
  localparam int IDX_W      = $clog2(NUM_HASHES);
  localparam int ACT_W      = 2;
  localparam int COEF_W     = 31;
  localparam int SHINGLE_W  = 32;
  localparam int HASH_W     = 33;
  localparam int PROD_W     = COEF_W + SHINGLE_W;
  localparam int RED1_W     = 37;
  localparam int RED2_W     = HASH_W + 1;
  localparam int MIN_ENTRY_W = HASH_W + 1;

  // p = 2^32 + 15, so 2^32 folds to -15 during reduction
  localparam logic [HASH_W-1:0] HASH_PRIME     = 33'd4294967311;
  localparam logic [RED1_W-1:0] HASH_PRIME_X16 = 37'd68719476976;

  // stages of the hash unit and wait after the last issue of a pass
  localparam int HASH_STAGES  = 5;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(NUM_HASHES - 1);
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(DRAIN_CYCLES - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_DRAIN,
    ST_RESP
  } mhs_state_t;

  typedef struct packed {
    logic             stall;
    logic             coef_we;
    logic             x_load;
    logic             rd_start;
    logic             clr_we;
    logic             issue;
    logic             resp_load;
    logic [IDX_W-1:0] idx;
  } mhs_ctrl_t;

endpackage

// ===== rtl/mhs_ram.sv =====
`timescale 1ns / 1ps
module mhs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mhs_hash_unit.sv =====
`timescale 1ns / 1ps
module mhs_hash_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [mhs_pkg::IDX_W-1:0]      in_idx,
  input  logic [mhs_pkg::COEF_W-1:0]     coef_a,
  input  logic [mhs_pkg::COEF_W-1:0]     coef_b,
  input  logic [mhs_pkg::SHINGLE_W-1:0]  shingle,
  output logic                           out_valid,
  output logic [mhs_pkg::IDX_W-1:0]      out_idx,
  output logic [mhs_pkg::HASH_W-1:0]     out_hash,
  output logic                           busy
);
  import mhs_pkg::*;

  logic [HASH_STAGES-1:0] vld_r;
  logic [IDX_W-1:0]       idx_r [HASH_STAGES];

  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [COEF_W-1:0] b_r;
  logic [PROD_W-1:0] sum_r, sum_nxt;
  logic [RED1_W-1:0] red1_r, red1_nxt, fold1;
  logic [RED2_W-1:0] red2_r, red2_nxt, red2_sub;
  logic [8:0]        fold2;
  logic [HASH_W-1:0] h_r, h_nxt;

  // (a*x + b) mod p: multiply, add, two folds of 2^32 = -15, final subtract
  assign prod_nxt = {{SHINGLE_W{1'b0}}, coef_a} * {{COEF_W{1'b0}}, shingle};
  assign sum_nxt  = prod_r + {{SHINGLE_W{1'b0}}, b_r};

  assign fold1    = {2'b0, sum_r[PROD_W-1:32], 4'b0} - {6'b0, sum_r[PROD_W-1:32]};
  assign red1_nxt = {5'b0, sum_r[31:0]} + HASH_PRIME_X16 - fold1;

  assign fold2    = {red1_r[RED1_W-1:32], 4'b0} - {4'b0, red1_r[RED1_W-1:32]};
  assign red2_nxt = {2'b0, red1_r[31:0]} + {1'b0, HASH_PRIME} - {25'b0, fold2};

  assign red2_sub = red2_r - {1'b0, HASH_PRIME};
  assign h_nxt    = (red2_r >= {1'b0, HASH_PRIME}) ? red2_sub[HASH_W-1:0]
                                                  : red2_r[HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[HASH_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0] <= in_idx;
    for (int k = 1; k < HASH_STAGES; k++) begin
      idx_r[k] <= idx_r[k-1];
    end
    prod_r <= prod_nxt;
    b_r    <= coef_b;
    sum_r  <= sum_nxt;
    red1_r <= red1_nxt;
    red2_r <= red2_nxt;
    h_r    <= h_nxt;
  end

  assign out_valid = vld_r[HASH_STAGES-1];
  assign out_idx   = idx_r[HASH_STAGES-1];
  assign out_hash  = h_r;
  assign busy      = |vld_r;

endmodule

// ===== rtl/mhs_seq.sv =====
`timescale 1ns / 1ps
module mhs_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [mhs_pkg::ACT_W-1:0]   in_action,
  input  logic                        out_free,
  output mhs_pkg::mhs_ctrl_t          ctrl
);
  import mhs_pkg::*;

  mhs_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [DRAIN_W-1:0] drain_r, drain_nxt;
  logic             accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == IDX_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_START: state_nxt = ST_CLEAR;
            ACT_ADD:   state_nxt = ST_HASH;
            ACT_READ:  state_nxt = ST_RESP;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_HASH: begin
        if (cnt_r == IDX_LAST) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_LAST) state_nxt = ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sweep index wraps back to zero at the end of each pass
  always_comb begin
    cnt_nxt   = (state_r inside {ST_CLEAR, ST_HASH}) ? cnt_r + 1'b1 : '0;
    drain_nxt = (state_r == ST_DRAIN) ? drain_r + 1'b1 : '0;
  end

  always_comb begin
    ctrl.stall     = (state_r != ST_IDLE);
    ctrl.coef_we   = accept && (in_action == ACT_LOAD);
    ctrl.x_load    = accept && (in_action == ACT_ADD);
    ctrl.rd_start  = accept && (in_action == ACT_READ);
    ctrl.clr_we    = (state_r == ST_CLEAR);
    ctrl.issue     = (state_r == ST_HASH);
    ctrl.resp_load = (state_r == ST_RESP) && out_free;
    ctrl.idx       = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ===== rtl/minhash_signature_engine.sv =====
`timescale 1ns / 1ps
// MinHash signature builder with NUM_HASHES (1024) universal hash functions.
// Input channel (in_valid / in_stall) carries one action per transaction:
//   load:  write coefficient pair (in_coeff_mul, in_coeff_add) at in_hash_index;
//          in_stall stays low.
//   start: mark every running minimum empty; the seen flags are swept one
//          entry per cycle.
//   add:   hash in_shingle_value with every function and keep the minimum;
//          one function per cycle through a 5-stage hash unit, plus a compare
//          and write-back stage; in_stall stays high until the pipeline drains.
//   read:  return the minimum at in_hash_index on the out_ channel; the entry
//          is read from the minimum RAM, then loaded into the free output register.
// in_stall is high while an action is in progress. The output register holds
// a finished result while out_stall is high; a read arriving then waits in
// the block, with in_stall high, until the register frees.
// After reset the seen flags are cleared by the same sweep, with in_stall high
// throughout.
module minhash_signature_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mhs_pkg::ACT_W-1:0]      in_action,
  input  logic [mhs_pkg::IDX_W-1:0]      in_hash_index,
  input  logic [mhs_pkg::COEF_W-1:0]     in_coeff_mul,
  input  logic [mhs_pkg::COEF_W-1:0]     in_coeff_add,
  input  logic [mhs_pkg::SHINGLE_W-1:0]  in_shingle_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mhs_pkg::HASH_W-1:0]     out_signature_value,
  output logic                           out_signature_empty
);
  import mhs_pkg::*;

  mhs_ctrl_t ctrl;
  logic      out_free;

  logic [SHINGLE_W-1:0] x_r;
  logic                 issue_v_r;
  logic [IDX_W-1:0]     issue_idx_r;
  logic [2*COEF_W-1:0]  coef_rdata;

  logic                 hash_valid;
  logic [IDX_W-1:0]     hash_idx;
  logic [HASH_W-1:0]    hash_h;
  logic                 hash_busy;

  logic                 cmp_valid_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic [HASH_W-1:0]    cmp_h_r;

  logic [MIN_ENTRY_W-1:0] min_rdata, min_wdata;
  logic [IDX_W-1:0]       min_waddr, min_raddr;
  logic                   min_we, min_re;
  logic                   entry_seen;
  logic [HASH_W-1:0]      entry_min;
  logic                   update;

  logic                 out_valid_r;
  logic [HASH_W-1:0]    out_value_r;
  logic                 out_empty_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = ctrl.stall;

  mhs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  mhs_ram #(
    .DEPTH (NUM_HASHES),
    .WIDTH (2 * COEF_W)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ctrl.coef_we),
    .waddr (in_hash_index),
    .wdata ({in_coeff_mul, in_coeff_add}),
    .re    (ctrl.issue),
    .raddr (ctrl.idx),
    .rdata (coef_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_v_r <= 1'b0;
    end else begin
      issue_v_r <= ctrl.issue;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx_r <= ctrl.idx;
    if (ctrl.x_load) begin
      x_r <= in_shingle_value;
    end
  end

  mhs_hash_unit u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue_v_r),
    .in_idx    (issue_idx_r),
    .coef_a    (coef_rdata[2*COEF_W-1:COEF_W]),
    .coef_b    (coef_rdata[COEF_W-1:0]),
    .shingle   (x_r),
    .out_valid (hash_valid),
    .out_idx   (hash_idx),
    .out_hash  (hash_h),
    .busy      (hash_busy)
  );

  // fetch the stored minimum while the fresh hash moves to the compare stage
  assign min_re    = hash_valid || ctrl.rd_start;
  assign min_raddr = hash_valid ? hash_idx : in_hash_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= hash_valid;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= hash_idx;
    cmp_h_r   <= hash_h;
  end

  assign entry_seen = min_rdata[MIN_ENTRY_W-1];
  assign entry_min  = min_rdata[HASH_W-1:0];
  assign update     = cmp_valid_r && (!entry_seen || (cmp_h_r < entry_min));

  always_comb begin
    if (ctrl.clr_we) begin
      min_we    = 1'b1;
      min_waddr = ctrl.idx;
      min_wdata = '0;
    end else begin
      min_we    = update;
      min_waddr = cmp_idx_r;
      min_wdata = {1'b1, cmp_h_r};
    end
  end

  mhs_ram #(
    .DEPTH (NUM_HASHES),
    .WIDTH (MIN_ENTRY_W)
  ) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_waddr),
    .wdata (min_wdata),
    .re    (min_re),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.resp_load) begin
      out_value_r <= entry_seen ? entry_min : '0;
      out_empty_r <= !entry_seen;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_signature_value = out_value_r;
  assign out_signature_empty = out_empty_r;

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.stall |-> !issue_v_r && !hash_busy && !cmp_valid_r)
    else $error("hash pipeline active while taking a new transaction");

  a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.clr_we && cmp_valid_r))
    else $error("clear sweep collides with minimum write-back");

  a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    hash_valid |-> hash_h < HASH_PRIME)
    else $error("hash result not reduced below the prime");

  a_resp_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.resp_load |=> out_valid_r && (out_empty_r == !$past(entry_seen)))
    else $error("read result not captured in the output register");

endmodule

// ===== tb/sv/minhash_signature_engine_checker.sv =====
`timescale 1ns / 1ps
module minhash_signature_engine_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [mhs_pkg::ACT_W-1:0]      in_action,
  input  logic [mhs_pkg::IDX_W-1:0]      in_hash_index,
  input  logic [mhs_pkg::COEF_W-1:0]     in_coeff_mul,
  input  logic [mhs_pkg::COEF_W-1:0]     in_coeff_add,
  input  logic [mhs_pkg::SHINGLE_W-1:0]  in_shingle_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [mhs_pkg::HASH_W-1:0]     out_signature_value,
  input  logic                           out_signature_empty,
  output int                             pending_reads,
  output int                             fail_count
);
  import mhs_pkg::*;

  typedef struct packed {
    logic [HASH_W-1:0] value;
    logic              empty;
  } sig_entry_t;

  logic [COEF_W-1:0] mul_coef [NUM_HASHES];
  logic [COEF_W-1:0] add_coef [NUM_HASHES];
  logic [HASH_W-1:0] min_hash [NUM_HASHES];
  bit                seen     [NUM_HASHES];
  sig_entry_t        expected_sigs [$];
  int                mismatches = 0;

  // (a * x + b) mod p, all in 64 bits: the product stays below 2^63
  function automatic logic [HASH_W-1:0] univ_hash(logic [COEF_W-1:0] a,
                                                  logic [COEF_W-1:0] b,
                                                  logic [SHINGLE_W-1:0] x);
    bit [63:0] sum;
    sum = {33'd0, a} * {32'd0, x} + {33'd0, b};
    sum = sum % {31'd0, HASH_PRIME};
    return sum[HASH_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [HASH_W-1:0] got,
                                 logic [HASH_W-1:0] want);
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    sig_entry_t        want;
    logic [HASH_W-1:0] h;
    if (!rst_n) begin
      foreach (seen[i]) seen[i] = 1'b0;
      expected_sigs.delete();
    end else begin
      // retire first: a read accepted at this edge cannot answer yet
      if (out_valid && !out_stall) begin
        if (expected_sigs.size() == 0) begin
          report_mismatch("result with no read outstanding", out_signature_value, '0);
        end else begin
          want = expected_sigs.pop_front();
          if (out_signature_value !== want.value)
            report_mismatch("signature_value", out_signature_value, want.value);
          if (out_signature_empty !== want.empty)
            report_mismatch("signature_empty", HASH_W'(out_signature_empty),
                            HASH_W'(want.empty));
        end
      end
      if (in_valid && !in_stall) begin
        case (action_t'(in_action))
          ACT_LOAD: begin
            mul_coef[in_hash_index] = in_coeff_mul;
            add_coef[in_hash_index] = in_coeff_add;
          end
          ACT_START: begin
            foreach (seen[i]) seen[i] = 1'b0;
          end
          ACT_ADD: begin
            for (int i = 0; i < NUM_HASHES; i++) begin
              h = univ_hash(mul_coef[i], add_coef[i], in_shingle_value);
              if (!seen[i] || h < min_hash[i]) begin
                min_hash[i] = h;
                seen[i]     = 1'b1;
              end
            end
          end
          default: begin
            if (seen[in_hash_index]) begin
              want.value = min_hash[in_hash_index];
              want.empty = 1'b0;
            end else begin
              want.value = '0;
              want.empty = 1'b1;
            end
            expected_sigs = {expected_sigs, want};
          end
        endcase
      end
    end
    pending_reads <= expected_sigs.size();
    fail_count    <= mismatches;
  end

endmodule

// ===== tb/sv/minhash_signature_engine_tb.sv =====
`timescale 1ns / 1ps
module minhash_signature_engine_tb;
  import mhs_pkg::*;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action        = ACT_LOAD;
  logic [IDX_W-1:0]     in_hash_index    = '0;
  logic [COEF_W-1:0]    in_coeff_mul     = '0;
  logic [COEF_W-1:0]    in_coeff_add     = '0;
  logic [SHINGLE_W-1:0] in_shingle_value = '0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic [HASH_W-1:0]    out_signature_value;
  logic                 out_signature_empty;

  int pending_reads;
  int fail_count;
  int send_idle_pct = 24;
  int recv_idle_pct = 71;
  int hold_request  = 0;
  int items_sent    = 0;

  minhash_signature_engine u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_hash_index       (in_hash_index),
    .in_coeff_mul        (in_coeff_mul),
    .in_coeff_add        (in_coeff_add),
    .in_shingle_value    (in_shingle_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_signature_value (out_signature_value),
    .out_signature_empty (out_signature_empty)
  );

  minhash_signature_engine_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_hash_index       (in_hash_index),
    .in_coeff_mul        (in_coeff_mul),
    .in_coeff_add        (in_coeff_add),
    .in_shingle_value    (in_shingle_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_signature_value (out_signature_value),
    .out_signature_empty (out_signature_empty),
    .pending_reads       (pending_reads),
    .fail_count          (fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall, or a long hold-off when the stimulus asks for one
  initial begin : receiver
    int hold_taken;
    int hold_left;
    hold_taken = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request != hold_taken) begin
        hold_taken = hold_request;
        hold_left  = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(7))
      0:       return '0;
      1:       return IDX_LAST;
      default: return IDX_W'($urandom_range(NUM_HASHES - 1));
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 31'd2147483646;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  function automatic logic [SHINGLE_W-1:0] pick_shingle();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  // offer one transaction and hold it until accepted
  task automatic send_action(action_t act, logic [IDX_W-1:0] idx,
                             logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                             logic [SHINGLE_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_hash_index    <= idx;
    in_coeff_mul     <= a;
    in_coeff_add     <= b;
    in_shingle_value <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic do_load(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] a,
                         logic [COEF_W-1:0] b);
    send_action(ACT_LOAD, idx, a, b, pick_shingle());
  endtask

  task automatic do_start();
    send_action(ACT_START, pick_index(), pick_coef(), pick_coef(), pick_shingle());
  endtask

  task automatic do_add(logic [SHINGLE_W-1:0] x);
    send_action(ACT_ADD, pick_index(), pick_coef(), pick_coef(), x);
  endtask

  task automatic do_read(logic [IDX_W-1:0] idx);
    send_action(ACT_READ, idx, pick_coef(), pick_coef(), pick_shingle());
  endtask

  // drop valid and hold until every outstanding read has answered
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads != 0) @(posedge clk);
  endtask

  // mostly whole sets (start, shingles with an occasional load, reads), some loose random transactions
  task automatic run_phase(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        do_start();
        repeat ($urandom_range(4, 1)) begin
          do_add(pick_shingle());
          if ($urandom_range(9) == 0) do_load(pick_index(), pick_coef(), pick_coef());
        end
        repeat ($urandom_range(8, 2)) do_read(pick_index());
      end else begin
        repeat ($urandom_range(6, 1))
          send_action(action_t'($urandom_range(3)), pick_index(), pick_coef(),
                      pick_coef(), pick_shingle());
      end
    end
  endtask

  initial begin : stimulus
    logic [COEF_W-1:0] ca;
    logic [COEF_W-1:0] cb;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // nothing seen since reset, nor after a start
    do_read('0);
    do_read(IDX_LAST);
    do_start();
    do_read(10'd5);

    // fill every coefficient pair before any shingle goes in
    for (int i = 0; i < NUM_HASHES; i++) begin
      ca = pick_coef();
      cb = pick_coef();
      case (i)
        0:              begin ca = '0;             cb = '0;             end
        1:              begin ca = '1;             cb = '1;             end
        2:              begin ca = 31'd2147483646; cb = 31'd2147483646; end
        5:              begin ca = '0;             cb = 31'd2147483646; end
        NUM_HASHES - 1: begin ca = 31'd1;          cb = '0;             end
        default: ;
      endcase
      do_load(IDX_W'(i), ca, cb);
    end

    do_add('0);
    do_read('0);
    do_read(10'd1);
    do_read(10'd2);
    do_read(10'd5);
    do_read(IDX_LAST);
    do_add('1);
    do_read(10'd1);
    do_read(10'd2);
    do_read(IDX_LAST);

    // new pair mid-set applies to later shingles only
    do_load(10'd3, pick_coef(), pick_coef());
    do_add(pick_shingle());
    do_read(10'd3);

    // long hold-off on the result side so the block backs up
    hold_request <= hold_request + 1;
    for (int i = 0; i < 5; i++) do_read(IDX_W'(i));
    do_load(10'd7, pick_coef(), pick_coef());
    wait_drained();

    do_start();
    do_read(10'd1);
    do_add(pick_shingle());
    do_read(10'd1);
    wait_drained();

    run_phase(195);
    wait_drained();
    send_idle_pct = 71;
    recv_idle_pct = 24;
    run_phase(195);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(190);

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
